@@ rtl/pygb_pkg.sv @@
package pygb_pkg;

    localparam int ATAN_STEPS = 24;
    localparam int ITER_W     = 5;
    localparam int XW         = 37;
    localparam int CW         = 30;
    localparam int BW         = 17;
    localparam int ACC_W      = 64;

    localparam logic [31:0] GAIN_Q30   = 32'd652032874;
    localparam logic [31:0] ANG_QUART  = 32'h4000_0000;
    localparam logic [31:0] ANG_3QUART = 32'hC000_0000;
    localparam logic [31:0] ANG_HALF   = 32'h8000_0000;
    localparam logic [31:0] ANG_RND    = 32'h0000_8000;

    localparam logic CMD_ODOM   = 1'b0;
    localparam logic CMD_TARGET = 1'b1;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_MAC,
        DP_SAVE_VY,
        DP_SAVE_VX,
        DP_YAW_PRE,
        DP_CORDIC_V,
        DP_YAW_DONE,
        DP_ROT_PRE,
        DP_CORDIC_R,
        DP_ROT_DONE,
        DP_SAVE_GX,
        DP_SAVE_GY,
        DP_EMIT
    } dp_op_t;

    typedef enum logic [2:0] {
        A_W,
        A_X,
        A_Y,
        A_Z,
        A_C,
        A_S
    } a_sel_t;

    typedef enum logic [2:0] {
        B_QY,
        B_QZ,
        B_DXL,
        B_DXH,
        B_DYL,
        B_DYH
    } b_sel_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_QWZ,
        S_QXY,
        S_SVY,
        S_QYY,
        S_QZZ,
        S_SVX,
        S_YPRE,
        S_YCOR,
        S_YDONE,
        S_RPRE,
        S_RCOR,
        S_RDONE,
        S_GX0,
        S_GX1,
        S_GX2,
        S_GX3,
        S_GXS,
        S_GY0,
        S_GY1,
        S_GY2,
        S_GY3,
        S_GYS,
        S_EMIT
    } state_t;

    typedef struct packed {
        dp_op_t              op;
        a_sel_t              a_sel;
        b_sel_t              b_sel;
        logic                hi;
        logic                neg;
        logic                clear;
        logic [ITER_W-1:0]   iter;
    } pygb_cmd_t;

    typedef struct packed {
        logic item_cmd;
        logic out_busy;
    } pygb_sts_t;

    function automatic logic [31:0] atan_at(input logic [ITER_W-1:0] idx);
        logic [31:0] r;
        case (idx)
            5'd0:    r = 32'h20000000;
            5'd1:    r = 32'h12E4051E;
            5'd2:    r = 32'h09FB385B;
            5'd3:    r = 32'h051111D4;
            5'd4:    r = 32'h028B0D43;
            5'd5:    r = 32'h0145D7E1;
            5'd6:    r = 32'h00A2F61E;
            5'd7:    r = 32'h00517C55;
            5'd8:    r = 32'h0028BE53;
            5'd9:    r = 32'h00145F2F;
            5'd10:   r = 32'h000A2F98;
            5'd11:   r = 32'h000517CC;
            5'd12:   r = 32'h00028BE6;
            5'd13:   r = 32'h000145F3;
            5'd14:   r = 32'h0000A2FA;
            5'd15:   r = 32'h0000517D;
            5'd16:   r = 32'h000028BE;
            5'd17:   r = 32'h0000145F;
            5'd18:   r = 32'h00000A30;
            5'd19:   r = 32'h00000518;
            5'd20:   r = 32'h0000028C;
            5'd21:   r = 32'h00000146;
            5'd22:   r = 32'h000000A3;
            5'd23:   r = 32'h00000051;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/pygb_if.sv @@
interface pygb_in_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;

    modport source (output valid, cmd, quat_w, quat_x, quat_y, quat_z, point_x, point_y,
                    input ready);
    modport sink (input valid, cmd, quat_w, quat_x, quat_y, quat_z, point_x, point_y,
                  output ready);
endinterface

interface pygb_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
    logic signed [15:0] heading;

    modport source (output valid, goal_x, goal_y, heading, input ready);
    modport sink (input valid, goal_x, goal_y, heading, output ready);
endinterface

@@ rtl/pygb_ctrl.sv @@
module pygb_ctrl
    import pygb_pkg::*;
#(
    parameter int STEPS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    input  pygb_sts_t sts,
    output pygb_cmd_t cmd
);

    localparam logic [ITER_W-1:0] LAST = ITER_W'(STEPS - 1);

    state_t            state_reg, state_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic              last;

    assign last = (iter_reg == LAST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            iter_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        iter_next  = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                    state_next = (sts.item_cmd == CMD_ODOM) ? S_QWZ : S_RPRE;
            end
            S_QWZ:   state_next = S_QXY;
            S_QXY:   state_next = S_SVY;
            S_SVY:   state_next = S_QYY;
            S_QYY:   state_next = S_QZZ;
            S_QZZ:   state_next = S_SVX;
            S_SVX:   state_next = S_YPRE;
            S_YPRE:  state_next = S_YCOR;
            S_YCOR:
            begin
                if (last)
                    state_next = S_YDONE;
                else
                    iter_next = iter_reg + 1'b1;
            end
            S_YDONE: state_next = S_IDLE;
            S_RPRE:  state_next = S_RCOR;
            S_RCOR:
            begin
                if (last)
                    state_next = S_RDONE;
                else
                    iter_next = iter_reg + 1'b1;
            end
            S_RDONE: state_next = S_GX0;
            S_GX0:   state_next = S_GX1;
            S_GX1:   state_next = S_GX2;
            S_GX2:   state_next = S_GX3;
            S_GX3:   state_next = S_GXS;
            S_GXS:   state_next = S_GY0;
            S_GY0:   state_next = S_GY1;
            S_GY1:   state_next = S_GY2;
            S_GY2:   state_next = S_GY3;
            S_GY3:   state_next = S_GYS;
            S_GYS:   state_next = S_EMIT;
            S_EMIT:
            begin
                if (!sts.out_busy)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        item_ready = (state_reg == S_IDLE);
        cmd        = '{op: DP_NOP, a_sel: A_W, b_sel: B_QY, hi: 1'b0, neg: 1'b0,
                       clear: 1'b0, iter: iter_reg};
        case (state_reg)
            S_IDLE:  if (item_valid) cmd.op = DP_LOAD;
            S_QWZ:
            begin
                cmd.op = DP_MAC; cmd.a_sel = A_W; cmd.b_sel = B_QZ; cmd.clear = 1'b1;
            end
            S_QXY:
            begin
                cmd.op = DP_MAC; cmd.a_sel = A_X; cmd.b_sel = B_QY;
            end
            S_SVY:   cmd.op = DP_SAVE_VY;
            S_QYY:
            begin
                cmd.op = DP_MAC; cmd.a_sel = A_Y; cmd.b_sel = B_QY; cmd.clear = 1'b1;
            end
            S_QZZ:
            begin
                cmd.op = DP_MAC; cmd.a_sel = A_Z; cmd.b_sel = B_QZ;
            end
            S_SVX:   cmd.op = DP_SAVE_VX;
            S_YPRE:  cmd.op = DP_YAW_PRE;
            S_YCOR:  cmd.op = DP_CORDIC_V;
            S_YDONE: cmd.op = DP_YAW_DONE;
            S_RPRE:  cmd.op = DP_ROT_PRE;
            S_RCOR:  cmd.op = DP_CORDIC_R;
            S_RDONE: cmd.op = DP_ROT_DONE;
            S_GX0:
            begin
                cmd.op = DP_MAC; cmd.a_sel = A_C; cmd.b_sel = B_DXL; cmd.clear = 1'b1;
            end
            S_GX1:
            begin
                cmd.op = DP_MAC; cmd.a_sel = A_C; cmd.b_sel = B_DXH; cmd.hi = 1'b1;
            end
            S_GX2:
            begin
                cmd.op = DP_MAC; cmd.a_sel = A_S; cmd.b_sel = B_DYL;
            end
            S_GX3:
            begin
                cmd.op = DP_MAC; cmd.a_sel = A_S; cmd.b_sel = B_DYH; cmd.hi = 1'b1;
            end
            S_GXS:   cmd.op = DP_SAVE_GX;
            S_GY0:
            begin
                cmd.op = DP_MAC; cmd.a_sel = A_C; cmd.b_sel = B_DYL; cmd.clear = 1'b1;
            end
            S_GY1:
            begin
                cmd.op = DP_MAC; cmd.a_sel = A_C; cmd.b_sel = B_DYH; cmd.hi = 1'b1;
            end
            S_GY2:
            begin
                cmd.op = DP_MAC; cmd.a_sel = A_S; cmd.b_sel = B_DXL; cmd.neg = 1'b1;
            end
            S_GY3:
            begin
                cmd.op = DP_MAC; cmd.a_sel = A_S; cmd.b_sel = B_DXH; cmd.hi = 1'b1;
                cmd.neg = 1'b1;
            end
            S_GYS:   cmd.op = DP_SAVE_GY;
            S_EMIT:  if (!sts.out_busy) cmd.op = DP_EMIT;
            default: cmd.op = DP_NOP;
        endcase
    end

endmodule

@@ rtl/pygb_dpath.sv @@
module pygb_dpath
    import pygb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  pygb_cmd_t          cmd,
    output pygb_sts_t          sts,
    input  logic               in_cmd,
    input  logic signed [15:0] in_quat_w,
    input  logic signed [15:0] in_quat_x,
    input  logic signed [15:0] in_quat_y,
    input  logic signed [15:0] in_quat_z,
    input  logic signed [31:0] in_point_x,
    input  logic signed [31:0] in_point_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] out_goal_x,
    output logic signed [31:0] out_goal_y,
    output logic signed [15:0] out_heading
);

    logic signed [15:0]    qw_reg, qx_reg, qy_reg, qz_reg;
    logic signed [31:0]    px_reg, py_reg;
    logic signed [31:0]    rx_reg, ry_reg;
    logic signed [15:0]    yaw_reg;
    logic signed [XW-1:0]  x_reg, y_reg;
    logic [31:0]           ang_reg;
    logic                  zero_reg, flip_reg;
    logic signed [32:0]    dx_reg, dy_reg;
    logic signed [CW-1:0]  c_reg, s_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [31:0]    gx_reg, gy_reg;
    logic                  out_valid_reg;
    logic signed [31:0]    ogx_reg, ogy_reg;
    logic signed [15:0]    ohd_reg;

    logic signed [CW-1:0]    a_val;
    logic signed [BW-1:0]    b_val;
    logic signed [CW+BW-1:0] prod;
    logic signed [ACC_W-1:0] term, acc_sum;
    logic signed [XW-1:0]    xs, ys, tx;
    logic [31:0]             tab;
    logic [31:0]             zrot, zq;
    logic signed [XW-1:0]    rnd_c, rnd_s;
    logic signed [ACC_W-1:0] rnd_acc;
    logic signed [35:0]      shifted;
    logic signed [31:0]      sat_val;

    assign sts.item_cmd = in_cmd;
    assign sts.out_busy = out_valid_reg && !out_ready;

    always_comb
    begin
        case (cmd.a_sel)
            A_W:     a_val = CW'(qw_reg);
            A_X:     a_val = CW'(qx_reg);
            A_Y:     a_val = CW'(qy_reg);
            A_Z:     a_val = CW'(qz_reg);
            A_C:     a_val = c_reg;
            A_S:     a_val = s_reg;
            default: a_val = '0;
        endcase
        case (cmd.b_sel)
            B_QY:    b_val = BW'(qy_reg);
            B_QZ:    b_val = BW'(qz_reg);
            B_DXL:   b_val = {1'b0, dx_reg[15:0]};
            B_DXH:   b_val = dx_reg[32:16];
            B_DYL:   b_val = {1'b0, dy_reg[15:0]};
            B_DYH:   b_val = dy_reg[32:16];
            default: b_val = '0;
        endcase
        prod    = a_val * b_val;
        term    = ACC_W'(prod);
        if (cmd.hi)
            term = term <<< 16;
        if (cmd.neg)
            term = -term;
        acc_sum = cmd.clear ? term : acc_reg + term;
    end

    always_comb
    begin
        tab     = atan_at(cmd.iter);
        xs      = x_reg >>> cmd.iter;
        ys      = y_reg >>> cmd.iter;
        zrot    = {yaw_reg, 16'h0000};
        zq      = zrot + ANG_QUART;
        tx      = flip_reg ? -x_reg : x_reg;
        rnd_c   = tx + XW'(2);
        tx      = flip_reg ? -y_reg : y_reg;
        rnd_s   = tx + XW'(2);
        rnd_acc = acc_reg + (ACC_W'(1) <<< 27);
        shifted = rnd_acc[63:28];
        if (shifted > 36'sd2147483647)
            sat_val = 32'sh7FFFFFFF;
        else if (shifted < -36'sd2147483648)
            sat_val = 32'sh80000000;
        else
            sat_val = shifted[31:0];
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            DP_LOAD:
            begin
                qw_reg <= in_quat_w;
                qx_reg <= in_quat_x;
                qy_reg <= in_quat_y;
                qz_reg <= in_quat_z;
                px_reg <= in_point_x;
                py_reg <= in_point_y;
            end
            DP_MAC:     acc_reg <= acc_sum;
            DP_SAVE_VY: y_reg <= XW'(acc_reg) <<< 1;
            DP_SAVE_VX: x_reg <= (XW'(1) <<< 30) - (XW'(acc_reg) <<< 1);
            DP_YAW_PRE:
            begin
                zero_reg <= (x_reg == '0) && (y_reg == '0);
                if (x_reg < 0)
                begin
                    if (y_reg >= 0)
                    begin
                        x_reg   <= y_reg;
                        y_reg   <= -x_reg;
                        ang_reg <= ANG_QUART;
                    end
                    else
                    begin
                        x_reg   <= -y_reg;
                        y_reg   <= x_reg;
                        ang_reg <= ANG_3QUART;
                    end
                end
                else
                    ang_reg <= '0;
            end
            DP_CORDIC_V:
            begin
                if (y_reg >= 0)
                begin
                    x_reg   <= x_reg + ys;
                    y_reg   <= y_reg - xs;
                    ang_reg <= ang_reg + tab;
                end
                else
                begin
                    x_reg   <= x_reg - ys;
                    y_reg   <= y_reg + xs;
                    ang_reg <= ang_reg - tab;
                end
            end
            DP_ROT_PRE:
            begin
                flip_reg <= zq[31];
                ang_reg  <= zq[31] ? zrot - ANG_HALF : zrot;
                x_reg    <= XW'(GAIN_Q30);
                y_reg    <= '0;
                dx_reg   <= {px_reg[31], px_reg} - {rx_reg[31], rx_reg};
                dy_reg   <= {py_reg[31], py_reg} - {ry_reg[31], ry_reg};
            end
            DP_CORDIC_R:
            begin
                if (!ang_reg[31])
                begin
                    x_reg   <= x_reg - ys;
                    y_reg   <= y_reg + xs;
                    ang_reg <= ang_reg - tab;
                end
                else
                begin
                    x_reg   <= x_reg + ys;
                    y_reg   <= y_reg - xs;
                    ang_reg <= ang_reg + tab;
                end
            end
            DP_ROT_DONE:
            begin
                c_reg <= rnd_c[CW+1:2];
                s_reg <= rnd_s[CW+1:2];
            end
            DP_SAVE_GX: gx_reg <= sat_val;
            DP_SAVE_GY: gy_reg <= sat_val;
            DP_EMIT:
            begin
                ogx_reg <= gx_reg;
                ogy_reg <= gy_reg;
                ohd_reg <= yaw_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_reg        <= '0;
            ry_reg        <= '0;
            yaw_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == DP_YAW_DONE)
            begin
                rx_reg  <= px_reg;
                ry_reg  <= py_reg;
                yaw_reg <= zero_reg ? 16'sd0 : 16'((ang_reg + ANG_RND) >> 16);
            end
            if (cmd.op == DP_EMIT)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_goal_x  = ogx_reg;
    assign out_goal_y  = ogy_reg;
    assign out_heading = ohd_reg;

endmodule

@@ rtl/pose_yaw_goal_to_body_frame_core.sv @@
// Pose yaw / body-frame goal core.
// Channels: item (sink) takes cmd, quat_w..quat_z, point_x, point_y; result
// (source) gives goal_x, goal_y, heading. A transaction completes when valid
// and ready are both high at a rising clk edge.
// cmd 0 (odometry): stores the position and the yaw found by a vectoring
// CORDIC; no result. CORDIC_ITERATIONS is capped at 24, the atan table length.
// cmd 1 (target): rotation CORDIC for sin/cos, then eight 30x17 multiply-
// accumulate steps on one shared multiplier; the result is registered, and
// item is ready again in the same cycle that result valid rises.
// Each item is finished before the next is taken, paced by the CORDIC
// iteration loop and, for a target, the shared multiplier sequence.
// Reset (rst_n low, asynchronous) clears the stored pose to zero and drops
// result valid. While the receiver stalls, the result holds in its output
// register and the next item is still taken and worked on; a second result
// waits until the first transaction completes.
module pose_yaw_goal_to_body_frame_core
    import pygb_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    pygb_in_if.sink   item,
    pygb_out_if.source result
);

    localparam int STEPS = (CORDIC_ITERATIONS > ATAN_STEPS) ? ATAN_STEPS : CORDIC_ITERATIONS;

    pygb_cmd_t cmd;
    pygb_sts_t sts;

    pygb_ctrl #(.STEPS(STEPS)) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    pygb_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .in_cmd      (item.cmd),
        .in_quat_w   (item.quat_w),
        .in_quat_x   (item.quat_x),
        .in_quat_y   (item.quat_y),
        .in_quat_z   (item.quat_z),
        .in_point_x  (item.point_x),
        .in_point_y  (item.point_y),
        .out_valid   (result.valid),
        .out_ready   (result.ready),
        .out_goal_x  (result.goal_x),
        .out_goal_y  (result.goal_y),
        .out_heading (result.heading)
    );

endmodule

@@ rtl/pygb_checker.sv @@
module pygb_checker
(
    input logic clk,
    input logic rst_n,
    input logic item_valid,
    input logic item_ready,
    input logic result_valid,
    input logic result_ready
);

    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !result_valid)
        else $error("result valid during reset");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped while stalled");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("ready stayed high after a transaction");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> !$past(item_valid && item_ready))
        else $error("result appeared right after a transaction");

endmodule

bind pose_yaw_goal_to_body_frame_core pygb_checker u_pygb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready)
);
